[design/vcgf_pkg.sv]
// vcgf_pkg: shared types and constants of the voxel count grid filter
// no dependencies; used by vcgf_div, voxel_count_grid_filter and the bench
package vcgf_pkg;

  // fixed field widths
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned VSIZE_W    = 16;
  localparam int unsigned DIM_W      = 6;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned OUT_CNT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  // grid index width, covers dimensions up to 512
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned FOUND_W    = 5;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_SIZE   = 2'd2,
    FUNC_NBR    = 2'd3
  } func_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_VSIZE    = 3'd3,
    CFG_DIM_X    = 3'd4,
    CFG_DIM_Y    = 3'd5,
    CFG_DIM_Z    = 3'd6
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_PT_RD,
    ST_PT_DAT,
    ST_SC_RD,
    ST_SC_DAT,
    ST_NB_STEP,
    ST_NB_DAT,
    ST_NB_END,
    ST_DONE
  } state_e;

endpackage

[design/vcgf_ram.sv]
// vcgf_ram: generic single-port synchronous ram with registered read
// no dependencies
module vcgf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32768,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[design/vcgf_div.sv]
// vcgf_div: restoring divider, one quotient bit per cycle
// depends on vcgf_pkg for the operand widths
module vcgf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vcgf_pkg::COORD_W-1:0]  dividend_i,
  input  logic [vcgf_pkg::VSIZE_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [vcgf_pkg::COORD_W-1:0]  quotient_o
);

  localparam int unsigned NW = vcgf_pkg::COORD_W;
  localparam int unsigned DW = vcgf_pkg::VSIZE_W;
  localparam int unsigned SW = $clog2(NW);

  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d, dvs_q;
  logic [SW-1:0] step_q, step_d;
  logic          run_q, run_d, done_q, done_d;
  logic [DW:0]   trial;

  // one restoring step
  always_comb begin
    trial  = {rem_q, quo_q[NW-1]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == SW'(NW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[design/voxel_count_grid_filter.sv]
// voxel_count_grid_filter: 3d voxel occupancy grid with point counts and filters
// depends on vcgf_pkg, vcgf_ram and vcgf_div
//
//  channel  | signals                                    | direction
//  ---------+--------------------------------------------+----------
//  command  | start_i, busy_o, func_i, coord_*_i, threshold_i | in, busy_o out
//  result   | done_o, count_o, in_range_o                | out
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i           | in
//
// after reset a clearing pass writes all MAX_DIM_X*MAX_DIM_Y*MAX_DIM_Z grid entries
// with busy_o high. insert and query bin the three axes in parallel with 32-step
// dividers, then read the grid entry and, for insert, update it; a point outside
// the grid skips the ram access. the size and neighbour filters scan every voxel in
// use through the single ram port, the neighbour filter also reading the neighbours
// of each filled voxel. a transfer on the command channel happens when start_i is
// high and busy_o low; the result shows for one cycle on done_o.
module voxel_count_grid_filter #(
  parameter int unsigned MAX_DIM_X  = 32,
  parameter int unsigned MAX_DIM_Y  = 32,
  parameter int unsigned MAX_DIM_Z  = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vcgf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vcgf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        func_i,
  input  logic signed [vcgf_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [vcgf_pkg::COORD_W-1:0] coord_y_i,
  input  logic signed [vcgf_pkg::COORD_W-1:0] coord_z_i,
  input  logic [vcgf_pkg::THR_W-1:0]        threshold_i,
  output logic                              done_o,
  output logic [vcgf_pkg::OUT_CNT_W-1:0]    count_o,
  output logic                              in_range_o
);

  localparam int unsigned CELLS = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned CW    = vcgf_pkg::COORD_W;
  localparam int unsigned IW    = vcgf_pkg::IDX_W;
  localparam int unsigned FW    = vcgf_pkg::FOUND_W;

  // configuration registers
  logic signed [CW-1:0]          org_x_q, org_y_q, org_z_q;
  logic [vcgf_pkg::VSIZE_W-1:0]  vsize_q;
  logic [vcgf_pkg::DIM_W-1:0]    dim_x_q, dim_y_q, dim_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      vsize_q <= 16'd1;
      dim_x_q <= 6'd32;
      dim_y_q <= 6'd32;
      dim_z_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vcgf_pkg::CFG_ORIGIN_X: org_x_q <= cfg_wdata_i;
        vcgf_pkg::CFG_ORIGIN_Y: org_y_q <= cfg_wdata_i;
        vcgf_pkg::CFG_ORIGIN_Z: org_z_q <= cfg_wdata_i;
        vcgf_pkg::CFG_VSIZE:    vsize_q <= cfg_wdata_i[vcgf_pkg::VSIZE_W-1:0];
        vcgf_pkg::CFG_DIM_X:    dim_x_q <= cfg_wdata_i[vcgf_pkg::DIM_W-1:0];
        vcgf_pkg::CFG_DIM_Y:    dim_y_q <= cfg_wdata_i[vcgf_pkg::DIM_W-1:0];
        vcgf_pkg::CFG_DIM_Z:    dim_z_q <= cfg_wdata_i[vcgf_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // effective dimensions and voxel size
  logic [IW-1:0] nx, ny, nz;
  logic [vcgf_pkg::VSIZE_W-1:0] vs_eff;
  assign nx = (IW'(dim_x_q) > IW'(MAX_DIM_X)) ? IW'(MAX_DIM_X) : IW'(dim_x_q);
  assign ny = (IW'(dim_y_q) > IW'(MAX_DIM_Y)) ? IW'(MAX_DIM_Y) : IW'(dim_y_q);
  assign nz = (IW'(dim_z_q) > IW'(MAX_DIM_Z)) ? IW'(MAX_DIM_Z) : IW'(dim_z_q);
  assign vs_eff = (vsize_q == '0) ? 16'd1 : vsize_q;

  function automatic logic [AW-1:0] cell_addr(logic [IW-1:0] a, logic [IW-1:0] b,
                                              logic [IW-1:0] c);
    logic [31:0] s;
    s = 32'(a) * 32'(MAX_DIM_Y * MAX_DIM_Z) + 32'(b) * 32'(MAX_DIM_Z) + 32'(c);
    return s[AW-1:0];
  endfunction

  // state
  vcgf_pkg::state_e state_q, state_d;
  vcgf_pkg::func_e  func_q, func_d;
  logic [vcgf_pkg::THR_W-1:0] thr_q, thr_d;
  logic [2:0]       neg_q, neg_d;
  logic [IW-1:0]    x_q, x_d, y_q, y_d, z_q, z_d;
  logic [1:0]       da_q, da_d, db_q, db_d, dc_q, dc_d;
  logic [FW-1:0]    found_q, found_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [vcgf_pkg::OUT_CNT_W-1:0] res_cnt_q, res_cnt_d;
  logic             res_inr_q, res_inr_d;

  // memory and divider connections
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;
  logic                  div_start;
  logic [2:0]            div_done;
  logic [CW-1:0]         quo [3];
  logic signed [CW:0]    diff_x, diff_y, diff_z;

  assign diff_x = {coord_x_i[CW-1], coord_x_i} - {org_x_q[CW-1], org_x_q};
  assign diff_y = {coord_y_i[CW-1], coord_y_i} - {org_y_q[CW-1], org_y_q};
  assign diff_z = {coord_z_i[CW-1], coord_z_i} - {org_z_q[CW-1], org_z_q};

  vcgf_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  vcgf_div u_div_x (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .dividend_i(diff_x[CW-1:0]), .divisor_i(vs_eff), .done_o(div_done[0]),
    .quotient_o(quo[0]));
  vcgf_div u_div_y (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .dividend_i(diff_y[CW-1:0]), .divisor_i(vs_eff), .done_o(div_done[1]),
    .quotient_o(quo[1]));
  vcgf_div u_div_z (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .dividend_i(diff_z[CW-1:0]), .divisor_i(vs_eff), .done_o(div_done[2]),
    .quotient_o(quo[2]));

  // shared conditions
  logic accept, pt_func, dims_zero, pt_in, div_all;
  logic last_x, last_y, last_z, scan_end, nb_last, nb_valid, sat;
  logic [IW:0] ax, ay, az;
  logic [COUNT_BITS-1:0] new_cnt;

  assign accept    = start_i && (state_q == vcgf_pkg::ST_IDLE);
  assign pt_func   = (func_i == vcgf_pkg::FUNC_INSERT) || (func_i == vcgf_pkg::FUNC_QUERY);
  assign dims_zero = (nx == '0) || (ny == '0) || (nz == '0);
  assign div_all   = &div_done;
  assign pt_in     = !neg_q[0] && (quo[0] < CW'(nx)) && !neg_q[1] && (quo[1] < CW'(ny))
                     && !neg_q[2] && (quo[2] < CW'(nz));
  assign last_x    = (IW'(x_q + 1'b1) >= nx);
  assign last_y    = (IW'(y_q + 1'b1) >= ny);
  assign last_z    = (IW'(z_q + 1'b1) >= nz);
  assign scan_end  = last_x && last_y && last_z;
  assign nb_last   = (da_q == 2'd2) && (db_q == 2'd2) && (dc_q == 2'd2);
  // neighbour at offset minus one wraps to a large value below zero
  assign ax = (IW + 1)'({1'b0, x_q} + (IW + 1)'(da_q) - 1'b1);
  assign ay = (IW + 1)'({1'b0, y_q} + (IW + 1)'(db_q) - 1'b1);
  assign az = (IW + 1)'({1'b0, z_q} + (IW + 1)'(dc_q) - 1'b1);
  assign nb_valid = (ax < {1'b0, nx}) && (ay < {1'b0, ny}) && (az < {1'b0, nz})
                    && !((da_q == 2'd1) && (db_q == 2'd1) && (dc_q == 2'd1));
  assign sat     = (mem_rdata == '1);
  assign new_cnt = ((func_q == vcgf_pkg::FUNC_INSERT) && !sat) ?
                   COUNT_BITS'(mem_rdata + 1'b1) : mem_rdata;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vcgf_pkg::ST_CLEAR:   if (clr_q == AW'(CELLS - 1)) state_d = vcgf_pkg::ST_IDLE;
      vcgf_pkg::ST_IDLE: begin
        if (start_i) begin
          if (pt_func)        state_d = vcgf_pkg::ST_DIV;
          else if (dims_zero) state_d = vcgf_pkg::ST_DONE;
          else                state_d = vcgf_pkg::ST_SC_RD;
        end
      end
      vcgf_pkg::ST_DIV: begin
        if (div_all) state_d = pt_in ? vcgf_pkg::ST_PT_RD : vcgf_pkg::ST_DONE;
      end
      vcgf_pkg::ST_PT_RD:   state_d = vcgf_pkg::ST_PT_DAT;
      vcgf_pkg::ST_PT_DAT:  state_d = vcgf_pkg::ST_DONE;
      vcgf_pkg::ST_SC_RD:   state_d = vcgf_pkg::ST_SC_DAT;
      vcgf_pkg::ST_SC_DAT: begin
        if ((func_q == vcgf_pkg::FUNC_NBR) && (mem_rdata != '0))
          state_d = vcgf_pkg::ST_NB_STEP;
        else
          state_d = scan_end ? vcgf_pkg::ST_DONE : vcgf_pkg::ST_SC_RD;
      end
      vcgf_pkg::ST_NB_STEP: begin
        if (nb_valid)     state_d = vcgf_pkg::ST_NB_DAT;
        else if (nb_last) state_d = vcgf_pkg::ST_NB_END;
      end
      vcgf_pkg::ST_NB_DAT:  state_d = nb_last ? vcgf_pkg::ST_NB_END : vcgf_pkg::ST_NB_STEP;
      vcgf_pkg::ST_NB_END:  state_d = scan_end ? vcgf_pkg::ST_DONE : vcgf_pkg::ST_SC_RD;
      vcgf_pkg::ST_DONE:    state_d = vcgf_pkg::ST_IDLE;
      default:              state_d = vcgf_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    func_d    = func_q;
    thr_d     = thr_q;
    neg_d     = neg_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    da_d      = da_q;
    db_d      = db_q;
    dc_d      = dc_q;
    found_d   = found_q;
    clr_d     = clr_q;
    res_cnt_d = res_cnt_q;
    res_inr_d = res_inr_q;
    mem_we    = 1'b0;
    mem_addr  = cell_addr(x_q, y_q, z_q);
    mem_wdata = '0;
    div_start = 1'b0;
    case (state_q)
      vcgf_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = AW'(clr_q + 1'b1);
      end
      vcgf_pkg::ST_IDLE: begin
        if (accept) begin
          func_d    = vcgf_pkg::func_e'(func_i);
          thr_d     = threshold_i;
          neg_d     = {diff_z[CW], diff_y[CW], diff_x[CW]};
          div_start = pt_func;
          res_cnt_d = '0;
          res_inr_d = 1'b0;
          x_d       = '0;
          y_d       = '0;
          z_d       = '0;
        end
      end
      vcgf_pkg::ST_DIV: begin
        if (div_all) begin
          x_d = quo[0][IW-1:0];
          y_d = quo[1][IW-1:0];
          z_d = quo[2][IW-1:0];
        end
      end
      vcgf_pkg::ST_PT_DAT: begin
        mem_we    = (func_q == vcgf_pkg::FUNC_INSERT) && !sat;
        mem_wdata = new_cnt;
        res_cnt_d = (32'(new_cnt) > 32'hFFFF) ? 16'hFFFF : 16'(new_cnt);
        res_inr_d = 1'b1;
      end
      vcgf_pkg::ST_SC_DAT: begin
        if ((func_q == vcgf_pkg::FUNC_NBR) && (mem_rdata != '0)) begin
          da_d    = '0;
          db_d    = '0;
          dc_d    = '0;
          found_d = '0;
        end else begin
          mem_we = (func_q == vcgf_pkg::FUNC_SIZE) && (mem_rdata != '0)
                   && (32'(mem_rdata) < 32'(thr_q));
        end
      end
      vcgf_pkg::ST_NB_STEP: begin
        mem_addr = cell_addr(ax[IW-1:0], ay[IW-1:0], az[IW-1:0]);
      end
      vcgf_pkg::ST_NB_DAT: begin
        if (mem_rdata != '0) found_d = FW'(found_q + 1'b1);
      end
      vcgf_pkg::ST_NB_END: begin
        mem_we = (16'(found_q) < thr_q);
      end
      default: ;
    endcase
    // step through the 3x3x3 neighbourhood
    if (((state_q == vcgf_pkg::ST_NB_STEP) && !nb_valid) ||
        (state_q == vcgf_pkg::ST_NB_DAT)) begin
      if (dc_q != 2'd2) begin
        dc_d = dc_q + 2'd1;
      end else begin
        dc_d = '0;
        if (db_q != 2'd2) begin
          db_d = db_q + 2'd1;
        end else begin
          db_d = '0;
          da_d = da_q + 2'd1;
        end
      end
    end
    // advance the scan in x, y, z order
    if ((state_q == vcgf_pkg::ST_NB_END) ||
        ((state_q == vcgf_pkg::ST_SC_DAT) &&
         !((func_q == vcgf_pkg::FUNC_NBR) && (mem_rdata != '0)))) begin
      if (!last_z) begin
        z_d = IW'(z_q + 1'b1);
      end else begin
        z_d = '0;
        if (!last_y) begin
          y_d = IW'(y_q + 1'b1);
        end else begin
          y_d = '0;
          x_d = IW'(x_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vcgf_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    thr_q     <= thr_d;
    neg_q     <= neg_d;
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    da_q      <= da_d;
    db_q      <= db_d;
    dc_q      <= dc_d;
    found_q   <= found_d;
    res_cnt_q <= res_cnt_d;
    res_inr_q <= res_inr_d;
  end

  assign busy_o     = (state_q != vcgf_pkg::ST_IDLE);
  assign done_o     = (state_q == vcgf_pkg::ST_DONE);
  assign count_o    = res_cnt_q;
  assign in_range_o = res_inr_q;

endmodule

[design/vcgf_checker.sv]
// vcgf_checker: port-level assertions for the voxel count grid filter
// bound to voxel_count_grid_filter; no other dependencies
module vcgf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [15:0] count_o,
  input logic        in_range_o
);

  // a result only appears while an operation is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobe while idle");

  // an accepted command makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("command transfer not taken");

  // one result per command, then back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o)) else $error("result not followed by idle");

  // out of range points and filters report zero count
  a_zero_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !in_range_o) |-> (count_o == 16'd0)) else $error("nonzero count out of range");

endmodule

bind voxel_count_grid_filter vcgf_checker u_vcgf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .done_o    (done_o),
  .count_o   (count_o),
  .in_range_o(in_range_o)
);

[bench/tb.sv]
// tb: self-checking bench for voxel_count_grid_filter, directed then random commands
// depends on vcgf_pkg and the voxel_count_grid_filter rtl
`timescale 1ns / 1ps

module tb;

  localparam int unsigned OUT_CNT_W  = vcgf_pkg::OUT_CNT_W;
  localparam int unsigned COORD_W    = vcgf_pkg::COORD_W;
  localparam int unsigned THR_W      = vcgf_pkg::THR_W;
  localparam int unsigned CFG_IDX_W  = vcgf_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = vcgf_pkg::CFG_DATA_W;

  localparam int unsigned GX = 32;
  localparam int unsigned GY = 32;
  localparam int unsigned GZ = 32;
  localparam int unsigned CELLS = GX * GY * GZ;
  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 210;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic                 in_range;
  } voxel_result_t;

  // grid model and queue of pending results
  class voxel_scoreboard;
    int unsigned   counts[CELLS];
    longint        org[3];
    int unsigned   vsize;
    int unsigned   dims[3];
    voxel_result_t pending[$];
    int unsigned   mismatches;

    function void clear_all();
      foreach (counts[i]) counts[i] = 0;
      foreach (org[i]) org[i] = 0;
      vsize = 1;
      foreach (dims[i]) dims[i] = 32;
      mismatches = 0;
    endfunction

    function void set_reg(vcgf_pkg::cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        vcgf_pkg::CFG_ORIGIN_X: org[0] = longint'($signed(v));
        vcgf_pkg::CFG_ORIGIN_Y: org[1] = longint'($signed(v));
        vcgf_pkg::CFG_ORIGIN_Z: org[2] = longint'($signed(v));
        vcgf_pkg::CFG_VSIZE:    vsize = v[15:0];
        vcgf_pkg::CFG_DIM_X:    dims[0] = v[5:0];
        vcgf_pkg::CFG_DIM_Y:    dims[1] = v[5:0];
        vcgf_pkg::CFG_DIM_Z:    dims[2] = v[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned span(int a);
      int unsigned lim;
      lim = (a == 0) ? GX : (a == 1) ? GY : GZ;
      return (dims[a] > lim) ? lim : dims[a];
    endfunction

    function int unsigned at(int unsigned x, int unsigned y, int unsigned z);
      return (x * GY + y) * GZ + z;
    endfunction

    // floor((coord - origin) / size) on one axis, 0 when out of range
    function bit bin_axis(logic [COORD_W-1:0] c, int a, output int unsigned idx);
      longint d;
      longint q;
      longint vs;
      d = longint'($signed(c)) - org[a];
      vs = (vsize == 0) ? 1 : vsize;
      idx = 0;
      if (d < 0) return 0;
      q = d / vs;
      if (q >= span(a)) return 0;
      idx = q;
      return 1;
    endfunction

    function void size_sweep(int unsigned thr);
      for (int x = 0; x < span(0); x++)
        for (int y = 0; y < span(1); y++)
          for (int z = 0; z < span(2); z++)
            if (counts[at(x, y, z)] != 0 && counts[at(x, y, z)] < thr)
              counts[at(x, y, z)] = 0;
    endfunction

    // in-place scan, x outer, z inner, neighbourhood clamped to the grid
    function void neighbour_sweep(int unsigned thr);
      int unsigned nx, ny, nz, filled;
      int a0, a1, b0, b1, c0, c1;
      nx = span(0);
      ny = span(1);
      nz = span(2);
      for (int x = 0; x < nx; x++)
        for (int y = 0; y < ny; y++)
          for (int z = 0; z < nz; z++) begin
            if (counts[at(x, y, z)] == 0) continue;
            a0 = (x > 0) ? x - 1 : 0;
            a1 = (x + 1 < nx) ? x + 1 : x;
            b0 = (y > 0) ? y - 1 : 0;
            b1 = (y + 1 < ny) ? y + 1 : y;
            c0 = (z > 0) ? z - 1 : 0;
            c1 = (z + 1 < nz) ? z + 1 : z;
            filled = 0;
            for (int a = a0; a <= a1; a++)
              for (int b = b0; b <= b1; b++)
                for (int c = c0; c <= c1; c++)
                  if (!(a == x && b == y && c == z) && counts[at(a, b, c)] != 0)
                    filled++;
            if (filled < thr) counts[at(x, y, z)] = 0;
          end
    endfunction

    function void note_command(vcgf_pkg::func_e f, logic [COORD_W-1:0] cx,
                               logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz,
                               logic [THR_W-1:0] thr);
      voxel_result_t r;
      int unsigned ix, iy, iz, p;
      r = '0;
      if (f == vcgf_pkg::FUNC_SIZE) size_sweep(thr);
      else if (f == vcgf_pkg::FUNC_NBR) neighbour_sweep(thr);
      else if (bin_axis(cx, 0, ix) && bin_axis(cy, 1, iy) && bin_axis(cz, 2, iz)) begin
        p = at(ix, iy, iz);
        if (f == vcgf_pkg::FUNC_INSERT && counts[p] < 65535) counts[p]++;
        r.count = (counts[p] > 65535) ? 16'hFFFF : counts[p][15:0];
        r.in_range = 1'b1;
      end
      pending = {pending, r};
    endfunction

    function void check_result(logic [OUT_CNT_W-1:0] cnt, logic inr);
      voxel_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: count=%0d in_range=%0b", cnt, inr);
        return;
      end
      e = pending.pop_front();
      if (cnt !== e.count || inr !== e.in_range) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: count exp %0d got %0d, in_range exp %0b got %0b",
                   e.count, cnt, e.in_range, inr);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [1:0]             func_i = '0;
  logic [COORD_W-1:0]     coord_x_i = '0;
  logic [COORD_W-1:0]     coord_y_i = '0;
  logic [COORD_W-1:0]     coord_z_i = '0;
  logic [THR_W-1:0]       threshold_i = '0;
  logic                   done_o;
  logic [OUT_CNT_W-1:0]   count_o;
  logic                   in_range_o;

  voxel_scoreboard grid_sb;
  int unsigned     cycles = 0;

  voxel_count_grid_filter u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start_i, .busy_o,
    .func_i, .coord_x_i, .coord_y_i, .coord_z_i, .threshold_i, .done_o,
    .count_o, .in_range_o
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result transfers
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) grid_sb.check_result(count_o, in_range_o);
  end

  // one command transfer, with a random gap in front
  task automatic send_cmd(vcgf_pkg::func_e f, logic [COORD_W-1:0] cx,
                          logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz,
                          logic [THR_W-1:0] thr);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    func_i <= f;
    coord_x_i <= cx;
    coord_y_i <= cy;
    coord_z_i <= cz;
    threshold_i <= thr;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    grid_sb.note_command(f, cx, cy, cz, thr);
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    start_i <= 1'b0;
    while (grid_sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(vcgf_pkg::cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    do @(posedge clk_i); while (busy_o !== 1'b0);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    grid_sb.set_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] vs, logic [31:0] dx, logic [31:0] dy,
                          logic [31:0] dz);
    write_reg(vcgf_pkg::CFG_ORIGIN_X, ox);
    write_reg(vcgf_pkg::CFG_ORIGIN_Y, oy);
    write_reg(vcgf_pkg::CFG_ORIGIN_Z, oz);
    write_reg(vcgf_pkg::CFG_VSIZE, vs);
    write_reg(vcgf_pkg::CFG_DIM_X, dx);
    write_reg(vcgf_pkg::CFG_DIM_Y, dy);
    write_reg(vcgf_pkg::CFG_DIM_Z, dz);
  endtask

  // mostly a point inside or just past the grid, sometimes any value
  function automatic logic [COORD_W-1:0] pick_coord(int a);
    longint vs;
    longint c;
    vs = (grid_sb.vsize == 0) ? 1 : grid_sb.vsize;
    if ($urandom_range(0, 7) == 0) return $urandom();
    c = grid_sb.org[a] + longint'($urandom_range(0, grid_sb.span(a))) * vs
        + longint'($urandom_range(0, vs - 1));
    if ($urandom_range(0, 15) == 0) c = grid_sb.org[a] - 1;
    return c[COORD_W-1:0];
  endfunction

  task automatic random_cmd();
    int unsigned r;
    logic [THR_W-1:0] thr;
    r = $urandom_range(0, 99);
    thr = THR_W'($urandom());
    if (r < 55)
      send_cmd(vcgf_pkg::FUNC_INSERT, pick_coord(0), pick_coord(1), pick_coord(2), thr);
    else if (r < 92)
      send_cmd(vcgf_pkg::FUNC_QUERY, pick_coord(0), pick_coord(1), pick_coord(2), thr);
    else if (r < 96)
      send_cmd(vcgf_pkg::FUNC_SIZE, $urandom(), $urandom(), $urandom(),
               ($urandom_range(0, 4) == 0) ? thr : THR_W'($urandom_range(0, 4)));
    else
      send_cmd(vcgf_pkg::FUNC_NBR, $urandom(), $urandom(), $urandom(),
               ($urandom_range(0, 4) == 0) ? thr : THR_W'($urandom_range(0, 9)));
  endtask

  initial begin
    logic [31:0] vs;
    grid_sb = new();
    grid_sb.clear_all();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default grid, corners, edges, extremes of the coordinates
    send_cmd(vcgf_pkg::FUNC_INSERT, 0, 0, 0, 16'hFFFF);
    send_cmd(vcgf_pkg::FUNC_INSERT, 0, 0, 0, 0);
    send_cmd(vcgf_pkg::FUNC_INSERT, 31, 31, 31, 0);
    send_cmd(vcgf_pkg::FUNC_INSERT, 1, 0, 0, 0);
    send_cmd(vcgf_pkg::FUNC_INSERT, 32, 0, 0, 0);
    send_cmd(vcgf_pkg::FUNC_INSERT, 0, -1, 0, 0);
    send_cmd(vcgf_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 0, 0, 0);
    send_cmd(vcgf_pkg::FUNC_QUERY, 0, 0, 32'h8000_0000, 0);
    send_cmd(vcgf_pkg::FUNC_QUERY, 0, 0, 0, 0);
    send_cmd(vcgf_pkg::FUNC_QUERY, 31, 31, 31, 0);
    send_cmd(vcgf_pkg::FUNC_SIZE, 0, 0, 0, 0);
    send_cmd(vcgf_pkg::FUNC_SIZE, 0, 0, 0, 2);
    send_cmd(vcgf_pkg::FUNC_QUERY, 1, 0, 0, 0);
    send_cmd(vcgf_pkg::FUNC_NBR, 0, 0, 0, 0);
    send_cmd(vcgf_pkg::FUNC_NBR, 0, 0, 0, 1);
    send_cmd(vcgf_pkg::FUNC_QUERY, 0, 0, 0, 0);
    drain();

    // extreme origins, widest voxel, dimension above maximum and zero
    set_grid(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'hFFFF, 63, 1, 0);
    send_cmd(vcgf_pkg::FUNC_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_cmd(vcgf_pkg::FUNC_SIZE, 0, 0, 0, 16'hFFFF);
    send_cmd(vcgf_pkg::FUNC_NBR, 0, 0, 0, 16'hFFFF);
    drain();
    set_grid(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 2, 1, 1);
    send_cmd(vcgf_pkg::FUNC_INSERT, 32'h8000_0001, 32'h7FFF_FFFF, 0, 0);
    send_cmd(vcgf_pkg::FUNC_QUERY, 32'h8000_0001, 32'h7FFF_FFFF, 0, 0);
    send_cmd(vcgf_pkg::FUNC_QUERY, 32'h8000_0002, 32'h7FFF_FFFF, 0, 0);
    send_cmd(vcgf_pkg::FUNC_NBR, 0, 0, 0, 1);
    drain();

    // random phases, small grids so the filters stay short
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: vs = 0;
        1: vs = $urandom_range(0, 16'hFFFF);
        default: vs = $urandom_range(1, 20);
      endcase
      set_grid(($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 100),
               ($urandom_range(0, 1) != 0) ? $urandom() : -$urandom_range(0, 100),
               $urandom(), vs,
               $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_cmd();
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (grid_sb.mismatches == 0 && grid_sb.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
